FILE: rtl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants of the composition classifier
// Model identifiers, profile codes, parse phases and the record step types.
// ----------------------------------------------------------------------------
package mcc_pkg;

  // length of the record header that is skipped
  localparam logic [3:0] HeaderLen = 4'd10;

  // known server model identifiers
  localparam logic [15:0] ModelOnoff     = 16'h1000;
  localparam logic [15:0] ModelLevel     = 16'h1002;
  localparam logic [15:0] ModelLightness = 16'h1300;
  localparam logic [15:0] ModelCtl       = 16'h1303;
  localparam logic [15:0] ModelHsl       = 16'h1307;
  localparam logic [15:0] ModelSensor    = 16'h1100;

  // model flag bit positions
  localparam int FlagOnoff     = 0;
  localparam int FlagLevel     = 1;
  localparam int FlagLightness = 2;
  localparam int FlagCtl       = 3;
  localparam int FlagHsl       = 4;
  localparam int FlagSensor    = 5;
  localparam int FlagCount     = 6;

  // device profile codes
  localparam logic [2:0] ProfUnknown   = 3'd0;
  localparam logic [2:0] ProfColorHsl  = 3'd1;
  localparam logic [2:0] ProfColorTemp = 3'd2;
  localparam logic [2:0] ProfDimmable  = 3'd3;
  localparam logic [2:0] ProfOnoff     = 3'd4;
  localparam logic [2:0] ProfTemp      = 3'd5;
  localparam logic [2:0] ProfVendor    = 3'd6;

  // element walk phases, one-hot
  typedef enum logic [6:0] {
    PH_EH0  = 7'b0000001,
    PH_EH1  = 7'b0000010,
    PH_EH2  = 7'b0000100,
    PH_EH3  = 7'b0001000,
    PH_MLO  = 7'b0010000,
    PH_MHI  = 7'b0100000,
    PH_SKIP = 7'b1000000
  } phase_t;

  // one byte handed to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } step_t;

  // classification of a finished record
  typedef struct packed {
    logic [2:0] profile;
    logic [7:0] elem_total;
  } result_t;

  // flag mask for a sig model identifier
  function automatic logic [FlagCount-1:0] model_mask(input logic [15:0] id);
    logic [FlagCount-1:0] m;
    m = '0;
    m[FlagOnoff]     = (id == ModelOnoff);
    m[FlagLevel]     = (id == ModelLevel);
    m[FlagLightness] = (id == ModelLightness);
    m[FlagCtl]       = (id == ModelCtl);
    m[FlagHsl]       = (id == ModelHsl);
    m[FlagSensor]    = (id == ModelSensor);
    return m;
  endfunction

  // priority encode the flags into a profile
  function automatic logic [2:0] pick_profile(input logic [FlagCount-1:0] f);
    logic [2:0] p;
    priority if (f[FlagHsl])                      p = ProfColorHsl;
    else if (f[FlagCtl])                          p = ProfColorTemp;
    else if (f[FlagLightness] || f[FlagLevel])    p = ProfDimmable;
    else if (f[FlagOnoff])                        p = ProfOnoff;
    else if (f[FlagSensor])                       p = ProfTemp;
    else                                          p = ProfVendor;
    return p;
  endfunction

endpackage

FILE: rtl/mesh_composition_classifier.sv
// ----------------------------------------------------------------------------
// mesh_composition_classifier: mesh node profile from composition data
// Byte stream in, one classification out per record.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries the composition record one byte per transfer, with
//   s_tlast on the final byte. Every record, of any length, gives exactly
//   one transfer on the m_* channel: the device profile and the number of
//   complete element headers (modulo 256). Bytes that are not last give no
//   output.
//   Path: a last byte taken into the input register is walked into the result
//   register once that register is free; m_tvalid is its valid bit.
//   Throughput: one byte per cycle unless a record end waits on the result;
//   the walker updates its counters once per byte in a single pass of logic
//   between the two registers.
//   Stall: while a result waits on m_tready, non-last bytes keep flowing;
//   only a second record end waits for the result register to drain.
//   Reset: rst clears both registers and the walker; the next byte is taken
//   as the first byte of a new record. After each record end the walker
//   returns to that state on its own.
// ----------------------------------------------------------------------------
module mesh_composition_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] profile, [10:3] elem_total, [15:11] zero
);

  logic             in_valid;
  logic [7:0]       in_data;
  logic             in_last;
  logic             advance;
  logic             load;
  mcc_pkg::step_t   step;
  mcc_pkg::result_t result;
  mcc_pkg::result_t out_data;
  logic             out_valid;

  // the held byte moves on unless it ends a record and the result is stuck
  assign advance  = !in_last || !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign load     = in_valid && advance && in_last;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign step.valid = in_valid && advance;
  assign step.data  = in_data;
  assign step.last  = in_last;

  mcc_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_data.elem_total, out_data.profile};

  // a record end that leaves the input register lands in the result register
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_last && advance |=> m_tvalid)
    else $error("record end gave no result");

  // a waiting result is never overwritten by the next record end
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |-> !load)
    else $error("pending result overwritten");

  // a stalled result stays offered and unchanged
  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

endmodule

FILE: rtl/mcc_parse.sv
// ----------------------------------------------------------------------------
// mcc_parse: composition record walker
// Skips the header, walks element records, flags known models and counts
// elements; gives the classification on the last byte of a record.
// ----------------------------------------------------------------------------
module mcc_parse (
  input  logic             clk,
  input  logic             rst,
  input  mcc_pkg::step_t   step,
  output mcc_pkg::result_t result
);

  logic [3:0]                     header_bytes_seen, header_bytes_seen_next;
  mcc_pkg::phase_t                parse_phase, parse_phase_next;
  logic [7:0]                     sig_models_left, sig_models_left_next;
  logic [7:0]                     vendor_count_hold, vendor_count_hold_next;
  logic [9:0]                     skip_bytes_left, skip_bytes_left_next;
  logic [7:0]                     model_id_low, model_id_low_next;
  logic [mcc_pkg::FlagCount-1:0]  model_flags, model_flags_next;
  logic [7:0]                     elements_seen, elements_seen_next;
  logic [7:0]                     sig_dec;
  logic [9:0]                     skip_dec;

  assign sig_dec  = sig_models_left - 8'd1;
  assign skip_dec = skip_bytes_left - 10'd1;

  // next state for one byte
  always_comb begin
    header_bytes_seen_next = header_bytes_seen;
    parse_phase_next       = parse_phase;
    sig_models_left_next   = sig_models_left;
    vendor_count_hold_next = vendor_count_hold;
    skip_bytes_left_next   = skip_bytes_left;
    model_id_low_next      = model_id_low;
    model_flags_next       = model_flags;
    elements_seen_next     = elements_seen;
    if (header_bytes_seen < mcc_pkg::HeaderLen) begin
      header_bytes_seen_next = header_bytes_seen + 4'd1;
    end else begin
      unique case (parse_phase)
        mcc_pkg::PH_EH1: begin
          parse_phase_next = mcc_pkg::PH_EH2;
        end
        mcc_pkg::PH_EH2: begin
          sig_models_left_next = step.data;
          parse_phase_next     = mcc_pkg::PH_EH3;
        end
        mcc_pkg::PH_EH3: begin
          vendor_count_hold_next = step.data;
          elements_seen_next     = elements_seen + 8'd1;
          if (sig_models_left != 8'd0) begin
            parse_phase_next = mcc_pkg::PH_MLO;
          end else if (step.data != 8'd0) begin
            skip_bytes_left_next = {step.data, 2'b00};
            parse_phase_next     = mcc_pkg::PH_SKIP;
          end else begin
            parse_phase_next = mcc_pkg::PH_EH0;
          end
        end
        mcc_pkg::PH_MLO: begin
          model_id_low_next = step.data;
          parse_phase_next  = mcc_pkg::PH_MHI;
        end
        mcc_pkg::PH_MHI: begin
          model_flags_next     = model_flags |
                                 mcc_pkg::model_mask({step.data, model_id_low});
          sig_models_left_next = sig_dec;
          if (sig_dec != 8'd0) begin
            parse_phase_next = mcc_pkg::PH_MLO;
          end else if (vendor_count_hold != 8'd0) begin
            skip_bytes_left_next = {vendor_count_hold, 2'b00};
            parse_phase_next     = mcc_pkg::PH_SKIP;
          end else begin
            parse_phase_next = mcc_pkg::PH_EH0;
          end
        end
        mcc_pkg::PH_SKIP: begin
          skip_bytes_left_next = skip_dec;
          if (skip_dec == 10'd0) begin
            parse_phase_next = mcc_pkg::PH_EH0;
          end
        end
        default: begin
          parse_phase_next = mcc_pkg::PH_EH1;
        end
      endcase
    end
  end

  // classification from the state after this byte
  always_comb begin
    if (header_bytes_seen_next < mcc_pkg::HeaderLen) begin
      result.profile    = mcc_pkg::ProfUnknown;
      result.elem_total = 8'd0;
    end else begin
      result.profile    = mcc_pkg::pick_profile(model_flags_next);
      result.elem_total = elements_seen_next;
    end
  end

  // state registers, cleared again after the last byte of a record
  always_ff @(posedge clk) begin
    if (rst || (step.valid && step.last)) begin
      header_bytes_seen <= '0;
      parse_phase       <= mcc_pkg::PH_EH0;
      sig_models_left   <= '0;
      vendor_count_hold <= '0;
      skip_bytes_left   <= '0;
      model_id_low      <= '0;
      model_flags       <= '0;
      elements_seen     <= '0;
    end else if (step.valid) begin
      header_bytes_seen <= header_bytes_seen_next;
      parse_phase       <= parse_phase_next;
      sig_models_left   <= sig_models_left_next;
      vendor_count_hold <= vendor_count_hold_next;
      skip_bytes_left   <= skip_bytes_left_next;
      model_id_low      <= model_id_low_next;
      model_flags       <= model_flags_next;
      elements_seen     <= elements_seen_next;
    end
  end

  // a record end leaves a fresh walker
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step.valid && step.last |=>
      header_bytes_seen == 4'd0 && elements_seen == 8'd0 && model_flags == '0)
    else $error("walker not cleared after record end");

  // header counter saturates at the header length
  a_header_bound: assert property (@(posedge clk) disable iff (rst)
    header_bytes_seen <= mcc_pkg::HeaderLen)
    else $error("header counter beyond header length");

  // no element walk before the header is done
  a_phase_in_header: assert property (@(posedge clk) disable iff (rst)
    header_bytes_seen < mcc_pkg::HeaderLen |->
      parse_phase == mcc_pkg::PH_EH0 && elements_seen == 8'd0)
    else $error("element walk started inside header");

endmodule

FILE: test/mesh_composition_classifier_tb.sv
// ----------------------------------------------------------------------------
// mesh_composition_classifier_tb: self-checking bench for the profile parser
// Feeds composition records byte by byte on the input stream and predicts
// each classification with an independent byte walker. Every output
// transfer is checked field by field against the oldest pending prediction.
// Both stream sides idle at random. The output side also holds off once for
// a long stretch so that the parser fills up and stalls its input.
// ----------------------------------------------------------------------------
module mesh_composition_classifier_tb;

  localparam int QuietLimit = 1000;
  localparam int LongHold   = 300;
  localparam int RandBytes  = 220;
  localparam int RandRecs   = 8;

  // one byte of a record as it waits for the driver
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // bench state
  feed_t            feed_q[$];
  logic [7:0]       rec[$];
  mcc_pkg::result_t verdicts_due[$];
  int               bytes_fed;
  int               records_queued;
  int               results_seen;
  int               hold_after = -1;
  int               gap_left;
  int               stall_left;
  int               quiet;
  int               errors;

  logic [15:0] known_ids [6] = '{mcc_pkg::ModelOnoff, mcc_pkg::ModelLevel,
                                 mcc_pkg::ModelLightness, mcc_pkg::ModelCtl,
                                 mcc_pkg::ModelHsl, mcc_pkg::ModelSensor};

  // walker copy used for prediction
  logic [3:0]      hdr_seen;
  mcc_pkg::phase_t walk_ph;
  logic [7:0]      sig_left;
  logic [7:0]      vend_hold;
  logic [9:0]      skip_left;
  logic [7:0]      id_lo;
  logic [5:0]      seen_flags;
  logic [7:0]      elems;

  mesh_composition_classifier u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock, period 10
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_walk();
    hdr_seen   = '0;
    walk_ph    = mcc_pkg::PH_EH0;
    sig_left   = '0;
    vend_hold  = '0;
    skip_left  = '0;
    id_lo      = '0;
    seen_flags = '0;
    elems      = '0;
  endfunction

  // after the last sig model: vendor entries or the next element
  function automatic void leave_models();
    if (vend_hold != 8'd0) begin
      skip_left = {vend_hold, 2'b00};
      walk_ph   = mcc_pkg::PH_SKIP;
    end else begin
      walk_ph = mcc_pkg::PH_EH0;
    end
  endfunction

  function automatic void flag_model(input logic [15:0] id);
    case (id)
      mcc_pkg::ModelOnoff:     seen_flags[mcc_pkg::FlagOnoff]     = 1'b1;
      mcc_pkg::ModelLevel:     seen_flags[mcc_pkg::FlagLevel]     = 1'b1;
      mcc_pkg::ModelLightness: seen_flags[mcc_pkg::FlagLightness] = 1'b1;
      mcc_pkg::ModelCtl:       seen_flags[mcc_pkg::FlagCtl]       = 1'b1;
      mcc_pkg::ModelHsl:       seen_flags[mcc_pkg::FlagHsl]       = 1'b1;
      mcc_pkg::ModelSensor:    seen_flags[mcc_pkg::FlagSensor]    = 1'b1;
      default: ;
    endcase
  endfunction

  // highest ranking server model wins
  function automatic logic [2:0] rank_profile(input logic [5:0] f);
    if (f[mcc_pkg::FlagHsl]) return mcc_pkg::ProfColorHsl;
    if (f[mcc_pkg::FlagCtl]) return mcc_pkg::ProfColorTemp;
    if (f[mcc_pkg::FlagLightness] || f[mcc_pkg::FlagLevel]) return mcc_pkg::ProfDimmable;
    if (f[mcc_pkg::FlagOnoff]) return mcc_pkg::ProfOnoff;
    if (f[mcc_pkg::FlagSensor]) return mcc_pkg::ProfTemp;
    return mcc_pkg::ProfVendor;
  endfunction

  // advance the walker by one byte, queue a verdict on the record end
  function automatic void walk_byte(input logic [7:0] b, input logic fin);
    mcc_pkg::result_t r;
    if (hdr_seen < mcc_pkg::HeaderLen) begin
      hdr_seen = hdr_seen + 4'd1;
    end else begin
      case (walk_ph)
        mcc_pkg::PH_EH1: walk_ph = mcc_pkg::PH_EH2;
        mcc_pkg::PH_EH2: begin
          sig_left = b;
          walk_ph  = mcc_pkg::PH_EH3;
        end
        mcc_pkg::PH_EH3: begin
          vend_hold = b;
          elems     = elems + 8'd1;
          if (sig_left != 8'd0) walk_ph = mcc_pkg::PH_MLO;
          else leave_models();
        end
        mcc_pkg::PH_MLO: begin
          id_lo   = b;
          walk_ph = mcc_pkg::PH_MHI;
        end
        mcc_pkg::PH_MHI: begin
          flag_model({b, id_lo});
          sig_left = sig_left - 8'd1;
          if (sig_left != 8'd0) walk_ph = mcc_pkg::PH_MLO;
          else leave_models();
        end
        mcc_pkg::PH_SKIP: begin
          skip_left = skip_left - 10'd1;
          if (skip_left == 10'd0) walk_ph = mcc_pkg::PH_EH0;
        end
        default: walk_ph = mcc_pkg::PH_EH1;
      endcase
    end
    if (fin) begin
      if (hdr_seen < mcc_pkg::HeaderLen) begin
        r.profile    = mcc_pkg::ProfUnknown;
        r.elem_total = 8'd0;
      end else begin
        r.profile    = rank_profile(seen_flags);
        r.elem_total = elems;
      end
      verdicts_due.push_back(r);
      clear_walk();
    end
  endfunction

  // ---------------------------------------------------------- record builder

  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return known_ids[$urandom_range(0, 5)];
    // near miss of a known identifier
    if (r < 7) return known_ids[$urandom_range(0, 5)] ^ (16'h1 << $urandom_range(0, 15));
    return 16'($urandom());
  endfunction

  function automatic void add_header();
    repeat (10) rec.push_back(8'($urandom()));
  endfunction

  // element with sig models all of one id (negative: random ids)
  function automatic void add_element(input int sig, input int vend, input int id_sel);
    logic [15:0] id;
    rec.push_back(8'($urandom()));
    rec.push_back(8'($urandom()));
    rec.push_back(8'(sig));
    rec.push_back(8'(vend));
    repeat (sig) begin
      id = (id_sel < 0) ? pick_id() : 16'(id_sel);
      rec.push_back(id[7:0]);
      rec.push_back(id[15:8]);
    end
    repeat (4 * vend) rec.push_back(8'($urandom()));
  endfunction

  // hand the record to the driver, tlast on its final byte
  function automatic void queue_record();
    feed_t f;
    foreach (rec[i]) begin
      f.data = rec[i];
      f.last = (i == rec.size() - 1);
      feed_q.push_back(f);
    end
    records_queued++;
    rec.delete();
  endfunction

  // ------------------------------------------------------------------ driver

  always @(posedge clk) begin : drive_bytes
    logic  offer;
    feed_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        walk_byte(s_tdata, s_tlast);
        bytes_fed++;
        offer = 1'b0;
        // every fourth run of 64 bytes goes without gaps
        gap_left = ((bytes_fed / 64) % 4 == 3) ? 0 : $urandom_range(0, 10);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (feed_q.size() > 0) begin
          nxt = feed_q.pop_front();
          s_tdata <= nxt.data;
          s_tlast <= nxt.last;
          offer = 1'b1;
        end
      end
      s_tvalid <= offer;
    end
  end

  // ----------------------------------------------------------------- monitor

  task automatic report_miss(input string what, input int got, input int want);
    $display("result %0d: %s got %0d, want %0d", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : take_results
    logic             take;
    mcc_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      take = m_tready;
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          report_miss("transfer with nothing due, tdata", m_tdata, 0);
        end else begin
          want = verdicts_due.pop_front();
          if (m_tdata[2:0] !== want.profile)
            report_miss("profile", m_tdata[2:0], want.profile);
          if (m_tdata[10:3] !== want.elem_total)
            report_miss("elem_total", m_tdata[10:3], want.elem_total);
          if (m_tdata[15:11] !== 5'd0)
            report_miss("padding", m_tdata[15:11], 0);
        end
        take = 1'b0;
        // one stretch in three accepts without stalls
        stall_left = ((results_seen / 16) % 3 == 2) ? 0 : $urandom_range(0, 10);
        // long hold-off while the short record burst keeps coming
        if (results_seen == hold_after) stall_left = LongHold;
      end
      if (!take) begin
        if (stall_left > 0) stall_left--;
        else take = 1'b1;
      end
      m_tready <= take;
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("no transfer for %0d cycles, %0d results still due",
               quiet, verdicts_due.size());
      $display("mesh_composition_classifier_tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // -------------------------------------------------------------- stimulus

  initial begin : stimulus
    int kind;
    int rand_bytes;
    int rand_recs;
    int first_rand;
    clear_walk();

    // short record, a single byte
    rec.push_back(8'h00);
    queue_record();
    // short record, one byte short of the header
    repeat (9) rec.push_back(8'hFF);
    queue_record();
    // header only
    add_header();
    queue_record();
    // one element per known server model, then an unknown one
    foreach (known_ids[i]) begin
      add_header();
      add_element(1, 0, known_ids[i]);
      queue_record();
    end
    add_header();
    add_element(1, 0, 16'hFFFF);
    queue_record();
    // priority across several elements
    add_header();
    add_element(1, 0, mcc_pkg::ModelOnoff);
    add_element(1, 1, mcc_pkg::ModelSensor);
    add_element(2, 0, mcc_pkg::ModelHsl);
    queue_record();
    // zero sig and vendor counts
    add_header();
    repeat (3) add_element(0, 0, -1);
    queue_record();
    // vendor entries between elements
    add_header();
    add_element(0, 2, -1);
    add_element(1, 0, mcc_pkg::ModelCtl);
    queue_record();
    // partial element header is not counted
    add_header();
    add_element(0, 0, -1);
    rec.push_back(8'h01);
    rec.push_back(8'h02);
    rec.push_back(8'h03);
    queue_record();
    // half a model id sets no flag
    add_header();
    add_element(1, 0, mcc_pkg::ModelHsl);
    void'(rec.pop_back());
    queue_record();
    // vendor entries cut short
    add_header();
    add_element(0, 3, -1);
    repeat (5) void'(rec.pop_back());
    queue_record();
    // long vendor skip, 128 bytes
    add_header();
    add_element(0, 32, -1);
    add_element(1, 0, mcc_pkg::ModelLevel);
    queue_record();
    // long run of sig models
    add_header();
    add_element(40, 0, mcc_pkg::ModelLightness);
    queue_record();

    // burst of short records met by the long output hold-off
    hold_after = records_queued;
    repeat (12) begin
      repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom()));
      queue_record();
    end

    // random records, mostly well formed
    first_rand = feed_q.size();
    rand_recs  = 0;
    rand_bytes = 0;
    while (rand_bytes < RandBytes || rand_recs < RandRecs) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 9)) rec.push_back(8'($urandom()));
      end else if (kind < 15) begin
        add_header();
      end else if (kind < 27) begin
        add_header();
        repeat ($urandom_range(1, 30)) rec.push_back(8'($urandom()));
      end else begin
        add_header();
        repeat ($urandom_range(0, 3))
          add_element(($urandom_range(0, 15) == 0) ? $urandom_range(4, 12)
                                                   : $urandom_range(0, 3),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(3, 8)
                                                  : $urandom_range(0, 2),
                      -1);
        // some records are cut off anywhere
        if ($urandom_range(0, 4) == 0)
          while (rec.size() > $urandom_range(1, rec.size())) void'(rec.pop_back());
      end
      queue_record();
      rand_recs++;
      rand_bytes = feed_q.size() - first_rand;
    end

    // drain: everything sent and every verdict checked
    while (rst || feed_q.size() != 0 || s_tvalid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("fed %0d bytes in %0d records, checked %0d classifications",
             bytes_fed, records_queued, results_seen);
    $display("short, header-only, truncated, long vendor skip and hold-off seen");
    if (errors == 0) begin
      $display("mesh_composition_classifier_tb: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("mesh_composition_classifier_tb: errors");
    end
    $finish;
  end

endmodule
